@@ rtl/core/mrrb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrb_pkg
// types, codes and state encoding shared by the ring buffer modules
// ----------------------------------------------------------------------------
package mrrb_pkg;

    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_FLUSH  = 3'd2;
    localparam logic [2:0] OP_ATTACH = 3'd3;
    localparam logic [2:0] OP_CLOSE  = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY_FULL = 2'd1;
    localparam logic [1:0] ST_NOT_OPEN   = 2'd2;
    localparam logic [1:0] ST_NO_SLOT    = 2'd3;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] client_id;
        logic       end_select;
        logic [7:0] data_in;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data_out;
        logic [11:0] reclaimed;
        logic        released;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_RDWAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic read_pending;
    } sts_t;

endpackage

@@ rtl/core/mrrb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrb_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module mrrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/core/mrrb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrb_ctrl
// sequencer: load word, scan slots, execute, wait for ram, present result
// ----------------------------------------------------------------------------
module mrrb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output mrrb_pkg::cmd_t    cmd,
    input  mrrb_pkg::sts_t    sts
);
    mrrb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrrb_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mrrb_pkg::S_IDLE: begin
                if (s_valid) state_next = mrrb_pkg::S_SCAN;
            end
            mrrb_pkg::S_SCAN: begin
                if (sts.scan_done) state_next = mrrb_pkg::S_EXEC;
            end
            mrrb_pkg::S_EXEC: begin
                state_next = sts.read_pending ? mrrb_pkg::S_RDWAIT : mrrb_pkg::S_OUT;
            end
            mrrb_pkg::S_RDWAIT: state_next = mrrb_pkg::S_OUT;
            mrrb_pkg::S_OUT: begin
                if (m_ready) state_next = mrrb_pkg::S_IDLE;
            end
            default: state_next = mrrb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            mrrb_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            mrrb_pkg::S_SCAN:   cmd.scan = 1'b1;
            mrrb_pkg::S_EXEC:   cmd.exec = 1'b1;
            mrrb_pkg::S_RDWAIT: cmd.capture = 1'b1;
            mrrb_pkg::S_OUT:    m_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

@@ rtl/core/mrrb_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrb_dp
// pointers, client slots, slot scan unit and byte store
// ----------------------------------------------------------------------------
module mrrb_dp #(
    parameter int BUFFER_DEPTH = 4096,
    parameter int CLIENT_SLOTS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mrrb_pkg::in_word_t  s_data,
    output mrrb_pkg::out_word_t m_data,
    input  mrrb_pkg::cmd_t      cmd,
    output mrrb_pkg::sts_t      sts
);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam logic [AW-1:0] LAST = AW'(BUFFER_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(BUFFER_DEPTH);

    mrrb_pkg::in_word_t  in_reg;
    mrrb_pkg::out_word_t out_reg, out_next;

    logic [AW-1:0] wp_reg, wp_next, op_reg, op_next;
    logic [CLIENT_SLOTS-1:0] use_reg, use_next, ro_reg, ro_next, wo_reg, wo_next;
    logic [7:0]    cl_reg  [CLIENT_SLOTS];
    logic [7:0]    cl_next [CLIENT_SLOTS];
    logic [AW-1:0] rp_reg  [CLIENT_SLOTS];
    logic [AW-1:0] rp_next [CLIENT_SLOTS];

    // scan state
    logic [SW:0]   idx_reg;
    logic          hit_reg, free_reg, any_reg;
    logic [SW-1:0] hit_idx_reg, free_idx_reg;
    logic [AW-1:0] best_reg, target_reg;
    logic          rd_pend_next;

    logic [SW-1:0] si;
    logic [AW-1:0] lag;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;

    assign si   = idx_reg[SW-1:0];
    assign lag  = rp_reg[si] - op_reg + ((rp_reg[si] < op_reg) ? DEPTH_W[AW-1:0] : '0);
    assign sts.scan_done    = (idx_reg == (SW+1)'(CLIENT_SLOTS - 1));
    assign sts.read_pending = rd_pend_next;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.load) in_reg <= s_data;
        if (!aresetn || cmd.load) begin
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            any_reg <= 1'b0;
        end else if (cmd.scan) begin
            if (use_reg[si] && cl_reg[si] == in_reg.client_id && !hit_reg) begin
                hit_reg <= 1'b1;
                hit_idx_reg <= si;
            end
            if (!use_reg[si] && !free_reg) begin
                free_reg <= 1'b1;
                free_idx_reg <= si;
            end
            if (use_reg[si] && ro_reg[si] && (!any_reg || lag < best_reg)) begin
                any_reg <= 1'b1;
                best_reg <= lag;
                target_reg <= rp_reg[si];
            end
            if (!sts.scan_done) idx_reg <= idx_reg + 1'b1;
        end
    end

    always_comb begin
        logic [SW-1:0] s;
        logic found;
        wp_next = wp_reg; op_next = op_reg;
        use_next = use_reg; ro_next = ro_reg; wo_next = wo_reg;
        cl_next = cl_reg; rp_next = rp_reg;
        out_next = out_reg;
        rd_pend_next = 1'b0;
        ram_we = 1'b0;
        ram_addr = wp_reg;
        s = hit_idx_reg;
        found = hit_reg;
        if (cmd.exec) begin
            out_next = '0;
            out_next.status = mrrb_pkg::ST_OK;
            case (in_reg.operation)
                mrrb_pkg::OP_WRITE: begin
                    if (!found || !wo_reg[s]) out_next.status = mrrb_pkg::ST_NOT_OPEN;
                    else if (nxt(wp_reg) == op_reg) out_next.status = mrrb_pkg::ST_EMPTY_FULL;
                    else begin
                        ram_we = 1'b1;
                        wp_next = nxt(wp_reg);
                    end
                end
                mrrb_pkg::OP_READ: begin
                    if (!found || !ro_reg[s]) out_next.status = mrrb_pkg::ST_NOT_OPEN;
                    else if (rp_reg[s] == wp_reg) out_next.status = mrrb_pkg::ST_EMPTY_FULL;
                    else begin
                        ram_addr = rp_reg[s];
                        rd_pend_next = 1'b1;
                        rp_next[s] = nxt(rp_reg[s]);
                    end
                end
                mrrb_pkg::OP_FLUSH: begin
                    if (any_reg) begin
                        op_next = target_reg;
                        out_next.reclaimed = ((AW+1)'(best_reg) > (AW+1)'(4095))
                            ? 12'd4095 : 12'(best_reg);
                    end
                end
                mrrb_pkg::OP_ATTACH: begin
                    if (!found && free_reg) begin
                        s = free_idx_reg;
                        found = 1'b1;
                        use_next[s] = 1'b1;
                        cl_next[s] = in_reg.client_id;
                        ro_next[s] = 1'b0;
                        wo_next[s] = 1'b0;
                        rp_next[s] = '0;
                    end
                    if (!found) out_next.status = mrrb_pkg::ST_NO_SLOT;
                    else if (in_reg.end_select) wo_next[s] = 1'b1;
                    else if (!ro_next[s]) begin
                        ro_next[s] = 1'b1;
                        rp_next[s] = op_reg;
                    end
                end
                mrrb_pkg::OP_CLOSE: begin
                    if (!found || (in_reg.end_select ? !wo_reg[s] : !ro_reg[s]))
                        out_next.status = mrrb_pkg::ST_NOT_OPEN;
                    else begin
                        if (in_reg.end_select) wo_next[s] = 1'b0;
                        else ro_next[s] = 1'b0;
                        if (!ro_next[s] && !wo_next[s]) use_next[s] = 1'b0;
                        if (use_next == '0) begin
                            wp_next = '0; op_next = '0;
                            ro_next = '0; wo_next = '0;
                            for (int i = 0; i < CLIENT_SLOTS; i++) begin
                                cl_next[i] = '0;
                                rp_next[i] = '0;
                            end
                            out_next.released = 1'b1;
                        end
                    end
                end
                default: out_next.status = mrrb_pkg::ST_NOT_OPEN;
            endcase
        end else if (cmd.capture) begin
            out_next.data_out = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (!aresetn) begin
            wp_reg <= '0; op_reg <= '0;
            use_reg <= '0; ro_reg <= '0; wo_reg <= '0;
            for (int i = 0; i < CLIENT_SLOTS; i++) begin
                cl_reg[i] <= '0;
                rp_reg[i] <= '0;
            end
        end else begin
            wp_reg <= wp_next; op_reg <= op_next;
            use_reg <= use_next; ro_reg <= ro_next; wo_reg <= wo_next;
            cl_reg <= cl_next; rp_reg <= rp_next;
        end
    end

    mrrb_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_reg.data_in),
        .rdata (ram_rdata)
    );

    assign m_data = out_reg;
endmodule

@@ rtl/core/multi_reader_ring_buffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_reader_ring_buffer
// byte ring buffer shared by one writer position and per-client readers
// ----------------------------------------------------------------------------
// s_ channel carries one command word (write, read, flush, attach, close);
// m_ channel returns one result word per command, in order.
// a command passes through an accept step, a slot scan over all CLIENT_SLOTS
// slots, an execute step and, for a successful read, a wait for the byte
// store's registered read before the result is presented on the m_ channel.
// a new word is taken only after the previous result has been taken.
// the slot scan walks one slot a cycle through a shared compare unit.
// one command is in flight at a time; s_ready is high only when idle.
// while the receiver holds m_ready low the result stays on m_data and no
// new word is accepted.
// reset clears pointers and slots at once; the byte store is not cleared,
// pointer rules keep unwritten bytes from being read.
// ----------------------------------------------------------------------------
module multi_reader_ring_buffer #(
    parameter int BUFFER_DEPTH = 4096,
    parameter int CLIENT_SLOTS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mrrb_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mrrb_pkg::out_word_t m_data
);
    mrrb_pkg::cmd_t cmd;
    mrrb_pkg::sts_t sts;

    mrrb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .sts(sts)
    );

    mrrb_dp #(.BUFFER_DEPTH(BUFFER_DEPTH), .CLIENT_SLOTS(CLIENT_SLOTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .s_data(s_data), .m_data(m_data),
        .cmd(cmd), .sts(sts)
    );
endmodule

@@ rtl/core/mrrb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrb_checker
// port level checks of the ring buffer handshake and result codes
// ----------------------------------------------------------------------------
module mrrb_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input mrrb_pkg::out_word_t m_data
);
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("word accepted while result pending");

    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result too early");

    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != mrrb_pkg::ST_OK |->
        m_data.data_out == '0 && m_data.reclaimed == '0 && !m_data.released)
        else $error("payload on failed word");
endmodule

bind multi_reader_ring_buffer mrrb_checker u_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_data(m_data)
);

@@ test/multi_reader_ring_buffer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_reader_ring_buffer_tb
// self-checking bench: command words go in on the s_ channel, a behavioral
// model of the ring buffer predicts each result word and a scoreboard
// compares every field in order, under several idle and stall phases
// ----------------------------------------------------------------------------
module multi_reader_ring_buffer_tb;

    localparam int DEPTH = 4096;
    localparam int SLOTS = 4;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN = 300;

    class ring_scoreboard;
        logic [7:0]  store [DEPTH];
        logic [11:0] wr_pos, old_pos;
        logic        used [SLOTS];
        logic [7:0]  owner [SLOTS];
        logic        rd_open [SLOTS];
        logic        wr_open [SLOTS];
        logic [11:0] rd_pos [SLOTS];
        mrrb_pkg::out_word_t pending [$];
        int          errors;
        int          checked;
        int          releases;
        int          fulls;
        int          flush_moves;

        function new();
            errors = 0;
            checked = 0;
            releases = 0;
            fulls = 0;
            flush_moves = 0;
            clear_state();
        endfunction

        function void clear_state();
            wr_pos = '0;
            old_pos = '0;
            for (int i = 0; i < SLOTS; i++) begin
                used[i] = 1'b0;
                owner[i] = '0;
                rd_open[i] = 1'b0;
                wr_open[i] = 1'b0;
                rd_pos[i] = '0;
            end
        endfunction

        function int lookup(logic [7:0] id);
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && owner[i] == id) return i;
            return -1;
        endfunction

        function void note_command(mrrb_pkg::in_word_t w);
            mrrb_pkg::out_word_t r;
            int s;
            logic any;
            logic [11:0] best, target, d;
            logic left;
            r = '0;
            r.status = mrrb_pkg::ST_OK;
            s = lookup(w.client_id);
            case (w.operation)
                mrrb_pkg::OP_WRITE: begin
                    if (s < 0 || !wr_open[s]) r.status = mrrb_pkg::ST_NOT_OPEN;
                    else if (wr_pos + 12'd1 == old_pos) begin
                        r.status = mrrb_pkg::ST_EMPTY_FULL;
                        fulls++;
                    end else begin
                        store[wr_pos] = w.data_in;
                        wr_pos = wr_pos + 12'd1;
                    end
                end
                mrrb_pkg::OP_READ: begin
                    if (s < 0 || !rd_open[s]) r.status = mrrb_pkg::ST_NOT_OPEN;
                    else if (rd_pos[s] == wr_pos) r.status = mrrb_pkg::ST_EMPTY_FULL;
                    else begin
                        r.data_out = store[rd_pos[s]];
                        rd_pos[s] = rd_pos[s] + 12'd1;
                    end
                end
                mrrb_pkg::OP_FLUSH: begin
                    any = 1'b0;
                    best = '0;
                    target = old_pos;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (used[i] && rd_open[i]) begin
                            d = rd_pos[i] - old_pos;
                            if (!any || d < best) begin
                                best = d;
                                target = rd_pos[i];
                                any = 1'b1;
                            end
                        end
                    end
                    if (any) begin
                        old_pos = target;
                        r.reclaimed = best;
                        if (best != 0) flush_moves++;
                    end
                end
                mrrb_pkg::OP_ATTACH: begin
                    if (s < 0) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (s < 0 && !used[i]) begin
                                s = i;
                                used[i] = 1'b1;
                                owner[i] = w.client_id;
                                rd_open[i] = 1'b0;
                                wr_open[i] = 1'b0;
                                rd_pos[i] = '0;
                            end
                        end
                    end
                    if (s < 0) r.status = mrrb_pkg::ST_NO_SLOT;
                    else if (w.end_select) wr_open[s] = 1'b1;
                    else if (!rd_open[s]) begin
                        rd_open[s] = 1'b1;
                        rd_pos[s] = old_pos;
                    end
                end
                mrrb_pkg::OP_CLOSE: begin
                    if (s < 0 || (w.end_select ? !wr_open[s] : !rd_open[s]))
                        r.status = mrrb_pkg::ST_NOT_OPEN;
                    else begin
                        if (w.end_select) wr_open[s] = 1'b0;
                        else rd_open[s] = 1'b0;
                        if (!rd_open[s] && !wr_open[s]) used[s] = 1'b0;
                        left = 1'b0;
                        for (int i = 0; i < SLOTS; i++) if (used[i]) left = 1'b1;
                        if (!left) begin
                            clear_state();
                            r.released = 1'b1;
                            releases++;
                        end
                    end
                end
                default: r.status = mrrb_pkg::ST_NOT_OPEN;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(mrrb_pkg::out_word_t got);
            mrrb_pkg::out_word_t exp_w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            checked++;
            if (got.status !== exp_w.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp_w.status, got.status);
                errors++;
            end
            if (got.data_out !== exp_w.data_out) begin
                $display("%0t: data_out expected %h actual %h", $time, exp_w.data_out,
                         got.data_out);
                errors++;
            end
            if (got.reclaimed !== exp_w.reclaimed) begin
                $display("%0t: reclaimed expected %0d actual %0d", $time, exp_w.reclaimed,
                         got.reclaimed);
                errors++;
            end
            if (got.released !== exp_w.released) begin
                $display("%0t: released expected %0d actual %0d", $time, exp_w.released,
                         got.released);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    mrrb_pkg::in_word_t  s_data;
    logic                m_valid;
    logic                m_ready;
    mrrb_pkg::out_word_t m_data;

    ring_scoreboard sb;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off;
    logic hold_req;
    logic hold_seen;
    int   idle_cycles;
    int   sent;

    multi_reader_ring_buffer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // receiver side, with a long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_off <= 0;
            hold_seen <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_off <= HOLD_LEN;
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_word(mrrb_pkg::in_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(w);
        sent++;
    endtask

    task automatic send_op(logic [2:0] op, logic [7:0] id, logic e, logic [7:0] d);
        mrrb_pkg::in_word_t w;
        w.operation = op;
        w.client_id = id;
        w.end_select = e;
        w.data_in = d;
        send_word(w);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // mostly well-formed traffic over a small client pool
    task automatic random_phase(int count);
        logic [7:0] ids [4];
        int pick;
        logic [7:0] id, rid, rdat;
        logic e;
        ids = '{8'h00, 8'hFF, 8'h5A, 8'($urandom_range(255))};
        for (int n = 0; n < count; n++) begin
            pick = int'($urandom_range(99));
            id = ids[2'($urandom_range(3))];
            rid = 8'($urandom_range(255));
            rdat = 8'($urandom_range(255));
            e = 1'($urandom_range(1));
            if (pick < 30)
                send_op(mrrb_pkg::OP_WRITE, id, e, rdat);
            else if (pick < 58)
                send_op(mrrb_pkg::OP_READ, id, e, rdat);
            else if (pick < 68)
                send_op(mrrb_pkg::OP_FLUSH, rid, e, rdat);
            else if (pick < 84)
                send_op(mrrb_pkg::OP_ATTACH, id, e, rdat);
            else if (pick < 92)
                send_op(mrrb_pkg::OP_CLOSE, id, e, rdat);
            else if (pick < 96)
                send_op(mrrb_pkg::OP_ATTACH, rid, e, rdat);
            else
                send_op(3'($urandom_range(7)), rid, e, rdat);
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        hold_req = 1'b0;
        sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: unknown client, undefined ops, opens, extremes, release
        send_op(mrrb_pkg::OP_WRITE, 8'h00, 1'b1, 8'hFF);
        send_op(mrrb_pkg::OP_READ, 8'hFF, 1'b0, 8'h00);
        send_op(3'd5, 8'h01, 1'b0, 8'h00);
        send_op(3'd7, 8'hFF, 1'b1, 8'hFF);
        send_op(mrrb_pkg::OP_FLUSH, 8'h10, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_CLOSE, 8'h10, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_ATTACH, 8'h00, 1'b1, 8'h00);
        send_op(mrrb_pkg::OP_ATTACH, 8'hFF, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_ATTACH, 8'h11, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_ATTACH, 8'h22, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_ATTACH, 8'h33, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_READ, 8'hFF, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_WRITE, 8'h00, 1'b1, 8'h00);
        send_op(mrrb_pkg::OP_WRITE, 8'h00, 1'b1, 8'hFF);
        send_op(mrrb_pkg::OP_ATTACH, 8'hFF, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_READ, 8'hFF, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_WRITE, 8'hFF, 1'b1, 8'h00);
        send_op(mrrb_pkg::OP_FLUSH, 8'h00, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_READ, 8'h11, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_CLOSE, 8'h00, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_CLOSE, 8'h00, 1'b1, 8'h00);
        send_op(mrrb_pkg::OP_CLOSE, 8'h11, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_CLOSE, 8'h22, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_CLOSE, 8'h33, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_CLOSE, 8'hFF, 1'b0, 8'h00);
        drain();

        // partial fill, then flush with no reader and with one
        send_op(mrrb_pkg::OP_ATTACH, 8'h42, 1'b1, 8'h00);
        for (int n = 0; n < 100; n++)
            send_op(mrrb_pkg::OP_WRITE, 8'h42, 1'b1, 8'($urandom_range(255)));
        send_op(mrrb_pkg::OP_FLUSH, 8'h42, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_ATTACH, 8'h42, 1'b0, 8'h00);
        for (int n = 0; n < 40; n++) send_op(mrrb_pkg::OP_READ, 8'h42, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_FLUSH, 8'h42, 1'b0, 8'h00);
        send_op(mrrb_pkg::OP_WRITE, 8'h42, 1'b1, 8'hA5);
        send_op(mrrb_pkg::OP_CLOSE, 8'h42, 1'b1, 8'h00);
        send_op(mrrb_pkg::OP_CLOSE, 8'h42, 1'b0, 8'h00);
        drain();

        random_phase(250);
        send_idle_pct = 87;
        random_phase(220);
        send_idle_pct = 0;
        recv_stall_pct = 87;
        random_phase(220);
        send_idle_pct = 11;
        recv_stall_pct = 11;
        random_phase(180);
        // sender pause until the block is fully drained
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_req <= !hold_req;
        random_phase(180);

        drain();
        repeat (20) @(posedge aclk);
        $display("ran %0d words, checked %0d results", sent, sb.checked);
        $display("full hits %0d, flush moves %0d, releases %0d", sb.fulls, sb.flush_moves,
                 sb.releases);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/mrrb_pkg.sv
rtl/core/mrrb_ram.sv
rtl/core/mrrb_ctrl.sv
rtl/core/mrrb_dp.sv
rtl/core/multi_reader_ring_buffer.sv
rtl/core/mrrb_checker.sv
test/multi_reader_ring_buffer_tb.sv
